FILE: rtl/core/kline_pkg.sv
// Shared types and constants for the K-line frame receiver.
package kline_pkg;

  localparam int APB_AW  = 4;
  localparam int APB_DW  = 32;

  localparam logic [7:0] HOST_ADDR_MASK = 8'h0f;
  localparam logic [7:0] ACK_BIT        = 8'h80;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_EXP_ADDR  = 2'd0;
  localparam logic [1:0] REG_HOST_MODE = 2'd1;
  localparam logic [1:0] REG_EXP_CMD   = 2'd2;
  localparam logic [1:0] REG_SKIP_CNT  = 2'd3;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REJECTED = 2'd1,
    ST_TIMEOUT  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN  = 3'd1,
    PH_CMD  = 3'd2,
    PH_SKIP = 3'd3,
    PH_DATA = 3'd4,
    PH_CHK  = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic       done_res;
    status_t    status;
    logic [7:0] frame_addr;
    logic [7:0] frame_cmd;
    logic [7:0] data_len;
    logic       checksum_ok;
  } result_t;

endpackage

FILE: rtl/core/kline_frame_receiver_unit.sv
// K-line frame receiver: parses address, length, command, skip, payload and checksum.
//
// Each accepted line byte or timeout event updates the parser state; its result, if any,
// is registered in the output or skid register. A new item can be accepted every cycle:
// the parser state update is one short step, and a two-entry output buffer (output register
// plus skid register) keeps accepting while one result waits. in_stall rises only when both
// entries hold results, so sustained throughput is one item per cycle whenever the result
// side takes one transfer per cycle. Configuration registers are read and written through
// the APB-style port; pready is always high.
module kline_frame_receiver_unit
  import kline_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  input  logic              in_timeout,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_data_byte,
  output logic              out_data_valid,
  output logic              out_done_res,
  output logic [1:0]        out_status,
  output logic [7:0]        out_frame_addr,
  output logic [7:0]        out_frame_cmd,
  output logic [7:0]        out_data_len,
  output logic              out_checksum_ok,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // configuration registers
  logic [7:0] exp_addr_r;
  logic       host_mode_r;
  logic [7:0] exp_cmd_r;
  logic [7:0] skip_cnt_r;

  logic [1:0] reg_idx;
  logic       cfg_wr;

  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_addr_r  <= '0;
      host_mode_r <= 1'b0;
      exp_cmd_r   <= '0;
      skip_cnt_r  <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_EXP_ADDR:  exp_addr_r  <= pwdata[7:0];
        REG_HOST_MODE: host_mode_r <= pwdata[0];
        REG_EXP_CMD:   exp_cmd_r   <= pwdata[7:0];
        REG_SKIP_CNT:  skip_cnt_r  <= pwdata[7:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_EXP_ADDR:  prdata = {{(APB_DW-8){1'b0}}, exp_addr_r};
      REG_HOST_MODE: prdata = {{(APB_DW-1){1'b0}}, host_mode_r};
      REG_EXP_CMD:   prdata = {{(APB_DW-8){1'b0}}, exp_cmd_r};
      REG_SKIP_CNT:  prdata = {{(APB_DW-8){1'b0}}, skip_cnt_r};
      default:       prdata = '0;
    endcase
  end

  // parser state
  phase_t     phase_r,     phase_nxt;
  logic [7:0] xor_r,       xor_nxt;
  logic [7:0] len_r,       len_nxt;
  logic [7:0] addr_r,      addr_nxt;
  logic [7:0] cmd_r,       cmd_nxt;
  logic [7:0] skip_left_r, skip_left_nxt;
  logic [7:0] data_left_r, data_left_nxt;
  logic [7:0] delivered_r, delivered_nxt;

  logic       in_xfer;
  logic [7:0] hunt_cmp;
  logic       cmd_accept;
  logic [9:0] payload_diff;
  logic [7:0] payload_cnt;
  logic [7:0] skip_dec;
  logic [7:0] data_dec;

  assign in_xfer      = in_valid && !in_stall;
  assign hunt_cmp     = host_mode_r ? (in_rx_byte & HOST_ADDR_MASK) : in_rx_byte;
  assign cmd_accept   = host_mode_r || (in_rx_byte == (exp_cmd_r | ACK_BIT));
  assign payload_diff = {2'b00, len_r} - 10'd2 - {2'b00, skip_cnt_r};
  assign payload_cnt  = (payload_diff[9] || payload_diff == 10'd0) ? 8'd0 : payload_diff[7:0];
  assign skip_dec     = skip_left_r - 8'd1;
  assign data_dec     = data_left_r - 8'd1;

  // next state
  always_comb begin
    phase_nxt     = phase_r;
    xor_nxt       = xor_r;
    len_nxt       = len_r;
    addr_nxt      = addr_r;
    cmd_nxt       = cmd_r;
    skip_left_nxt = skip_left_r;
    data_left_nxt = data_left_r;
    delivered_nxt = delivered_r;
    unique case (phase_r)
      PH_HUNT: begin
        if (!in_timeout && hunt_cmp == exp_addr_r) begin
          addr_nxt      = in_rx_byte;
          cmd_nxt       = '0;
          xor_nxt       = in_rx_byte;
          delivered_nxt = '0;
          phase_nxt     = PH_LEN;
        end
      end
      PH_CHK: phase_nxt = PH_HUNT;
      PH_LEN: begin
        if (in_timeout) begin
          phase_nxt = PH_HUNT;
        end else begin
          len_nxt   = in_rx_byte;
          xor_nxt   = xor_r ^ in_rx_byte;
          phase_nxt = PH_CMD;
        end
      end
      PH_CMD: begin
        if (in_timeout) begin
          phase_nxt = PH_HUNT;
        end else begin
          cmd_nxt = in_rx_byte;
          if (!cmd_accept) begin
            phase_nxt = PH_HUNT;
          end else begin
            xor_nxt       = xor_r ^ in_rx_byte;
            data_left_nxt = payload_cnt;
            skip_left_nxt = skip_cnt_r;
            if (skip_cnt_r != 8'd0)       phase_nxt = PH_SKIP;
            else if (payload_cnt != 8'd0) phase_nxt = PH_DATA;
            else                          phase_nxt = PH_CHK;
          end
        end
      end
      PH_SKIP: begin
        if (in_timeout) begin
          phase_nxt = PH_HUNT;
        end else begin
          xor_nxt       = xor_r ^ in_rx_byte;
          skip_left_nxt = skip_dec;
          if (skip_dec == 8'd0) begin
            phase_nxt = (data_left_r != 8'd0) ? PH_DATA : PH_CHK;
          end
        end
      end
      PH_DATA: begin
        if (in_timeout) begin
          phase_nxt = PH_HUNT;
        end else begin
          xor_nxt       = xor_r ^ in_rx_byte;
          delivered_nxt = delivered_r + 8'd1;
          data_left_nxt = data_dec;
          if (data_dec == 8'd0) phase_nxt = PH_CHK;
        end
      end
      default: phase_nxt = PH_HUNT;
    endcase
  end

  // result for this item
  logic    res_vld;
  result_t res;

  always_comb begin
    res_vld         = 1'b0;
    res.data_byte   = '0;
    res.data_valid  = 1'b0;
    res.done_res    = 1'b0;
    res.status      = ST_OK;
    res.frame_addr  = addr_r;
    res.frame_cmd   = cmd_r;
    res.data_len    = '0;
    res.checksum_ok = 1'b0;
    unique case (phase_r)
      PH_HUNT: begin
        res.frame_addr = '0;
        res.frame_cmd  = '0;
        if (in_timeout) begin
          res_vld      = 1'b1;
          res.done_res = 1'b1;
          res.status   = ST_TIMEOUT;
        end
      end
      PH_CHK: begin
        res_vld         = 1'b1;
        res.done_res    = 1'b1;
        res.data_len    = delivered_r;
        res.checksum_ok = !in_timeout && (in_rx_byte == xor_r);
      end
      PH_CMD: begin
        if (in_timeout) begin
          res_vld      = 1'b1;
          res.done_res = 1'b1;
          res.status   = ST_TIMEOUT;
          res.data_len = delivered_r;
        end else if (!cmd_accept) begin
          res_vld       = 1'b1;
          res.done_res  = 1'b1;
          res.status    = ST_REJECTED;
          res.frame_cmd = in_rx_byte;
        end
      end
      PH_DATA: begin
        res_vld = 1'b1;
        if (in_timeout) begin
          res.done_res = 1'b1;
          res.status   = ST_TIMEOUT;
          res.data_len = delivered_r;
        end else begin
          res.data_byte  = in_rx_byte;
          res.data_valid = 1'b1;
        end
      end
      default: begin
        // length and skip bytes report only a timeout
        if (in_timeout) begin
          res_vld      = 1'b1;
          res.done_res = 1'b1;
          res.status   = ST_TIMEOUT;
          res.data_len = delivered_r;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      xor_r       <= '0;
      len_r       <= '0;
      addr_r      <= '0;
      cmd_r       <= '0;
      skip_left_r <= '0;
      data_left_r <= '0;
      delivered_r <= '0;
    end else if (in_xfer) begin
      phase_r     <= phase_nxt;
      xor_r       <= xor_nxt;
      len_r       <= len_nxt;
      addr_r      <= addr_nxt;
      cmd_r       <= cmd_nxt;
      skip_left_r <= skip_left_nxt;
      data_left_r <= data_left_nxt;
      delivered_r <= delivered_nxt;
    end
  end

  // output register plus skid entry
  logic    out_vld_r;
  result_t out_r;
  logic    skid_vld_r;
  result_t skid_r;
  logic    new_res;

  assign new_res  = in_xfer && res_vld;
  assign in_stall = skid_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || !out_stall) begin
      // output slot frees: drain skid first, else take the new result
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= new_res;
      end
    end else if (new_res) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || !out_stall) begin
      if (skid_vld_r) out_r <= skid_r;
      else if (new_res) out_r <= res;
    end else if (new_res) begin
      skid_r <= res;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_data_byte   = out_r.data_byte;
  assign out_data_valid  = out_r.data_valid;
  assign out_done_res    = out_r.done_res;
  assign out_status      = out_r.status;
  assign out_frame_addr  = out_r.frame_addr;
  assign out_frame_cmd   = out_r.frame_cmd;
  assign out_data_len    = out_r.data_len;
  assign out_checksum_ok = out_r.checksum_ok;

endmodule

FILE: dv/tb_kline_frame_receiver_unit.sv
// Self-checking testbench for the K-line frame receiver: frame stimulus, parser predictor.
`timescale 1ns / 1ps

module tb_kline_frame_receiver_unit;
  import kline_pkg::*;

  localparam int GAP_PCT     = 36;
  localparam int ITEM_TARGET = 1400;
  localparam int CYCLE_LIMIT = 400000;
  localparam int QUIET_CYCLES = 8;
  localparam logic [8:0] TMO = 9'h100;

  typedef struct packed {
    logic [7:0] rx;
    logic       tmo;
  } line_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        in_rx_byte = 8'h00;
  logic              in_timeout = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        out_data_byte;
  logic              out_data_valid;
  logic              out_done_res;
  logic [1:0]        out_status;
  logic [7:0]        out_frame_addr;
  logic [7:0]        out_frame_cmd;
  logic [7:0]        out_data_len;
  logic              out_checksum_ok;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  kline_frame_receiver_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_rx_byte(in_rx_byte), .in_timeout(in_timeout),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_data_byte(out_data_byte), .out_data_valid(out_data_valid),
    .out_done_res(out_done_res), .out_status(out_status),
    .out_frame_addr(out_frame_addr), .out_frame_cmd(out_frame_cmd),
    .out_data_len(out_data_len), .out_checksum_ok(out_checksum_ok),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 0;
  end

  // Register copy as written through the configuration port
  logic [7:0] exp_addr_cfg = 8'h00;
  logic       host_cfg = 1'b0;
  logic [7:0] exp_cmd_cfg = 8'h00;
  logic [7:0] skip_cfg = 8'h00;

  // Frame parser state
  phase_t     rx_phase = PH_HUNT;
  logic [7:0] run_xor = 8'h00;
  logic [7:0] len_byte = 8'h00;
  logic [7:0] cap_addr = 8'h00;
  logic [7:0] cap_cmd = 8'h00;
  logic [7:0] skip_left = 8'h00;
  logic [7:0] data_left = 8'h00;
  logic [7:0] delivered = 8'h00;

  line_item_t line_items[$];
  result_t    expected_results[$];

  logic       no_gaps = 1'b0;
  int         items_queued = 0;
  int         fail_count = 0;
  int         cycle_cnt = 0;
  int         frames_ok = 0;
  int         frames_rejected = 0;
  int         timeouts_seen = 0;
  int         payload_bytes = 0;
  int         settings_used = 0;
  logic [8:0] warmup [0:26];

  function automatic void next_after_header();
    if (skip_left != 0) rx_phase = PH_SKIP;
    else if (data_left != 0) rx_phase = PH_DATA;
    else rx_phase = PH_CHK;
  endfunction

  // Advance the frame parser by one line byte or timeout; queue the result it causes
  function automatic void predict_line_item(input logic [7:0] b, input logic tmo);
    result_t r;
    int      n;
    r = '0;
    r.frame_addr = cap_addr;
    r.frame_cmd  = cap_cmd;
    if (rx_phase == PH_HUNT) begin
      if (tmo) begin
        r.frame_addr = 8'h00;
        r.frame_cmd  = 8'h00;
        r.done_res   = 1'b1;
        r.status     = ST_TIMEOUT;
        expected_results.push_back(r);
      end else if ((host_cfg ? (b & HOST_ADDR_MASK) : b) == exp_addr_cfg) begin
        cap_addr  = b;
        cap_cmd   = 8'h00;
        run_xor   = b;
        delivered = 8'h00;
        rx_phase  = PH_LEN;
      end
    end else if (rx_phase == PH_CHK) begin
      r.done_res    = 1'b1;
      r.status      = ST_OK;
      r.data_len    = delivered;
      r.checksum_ok = !tmo && (b == run_xor);
      expected_results.push_back(r);
      rx_phase = PH_HUNT;
    end else if (tmo) begin
      r.done_res = 1'b1;
      r.status   = ST_TIMEOUT;
      r.data_len = delivered;
      expected_results.push_back(r);
      rx_phase = PH_HUNT;
    end else begin
      case (rx_phase)
        PH_LEN: begin
          len_byte = b;
          run_xor  = run_xor ^ b;
          rx_phase = PH_CMD;
        end
        PH_CMD: begin
          cap_cmd = b;
          if (!host_cfg && b != (exp_cmd_cfg | ACK_BIT)) begin
            r.frame_cmd = b;
            r.done_res  = 1'b1;
            r.status    = ST_REJECTED;
            expected_results.push_back(r);
            rx_phase = PH_HUNT;
          end else begin
            run_xor   = run_xor ^ b;
            n         = int'(len_byte) - 2 - int'(skip_cfg);
            data_left = (n > 0) ? n[7:0] : 8'h00;
            skip_left = skip_cfg;
            next_after_header();
          end
        end
        PH_SKIP: begin
          run_xor   = run_xor ^ b;
          skip_left = skip_left - 8'd1;
          if (skip_left == 0) next_after_header();
        end
        default: begin
          run_xor   = run_xor ^ b;
          delivered = delivered + 8'd1;
          data_left = data_left - 8'd1;
          if (data_left == 0) rx_phase = PH_CHK;
          r.data_byte  = b;
          r.data_valid = 1'b1;
          expected_results.push_back(r);
        end
      endcase
    end
  endfunction

  // Input driver: hold a stalled transfer, otherwise offer the next pending item
  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      predict_line_item(in_rx_byte, in_timeout);
      void'(line_items.pop_front());
    end
    if (!in_valid || !in_stall) begin
      if (line_items.size() != 0 && $urandom_range(99) >= (no_gaps ? 0 : GAP_PCT)) begin
        in_valid   <= 1'b1;
        in_rx_byte <= line_items[0].rx;
        in_timeout <= line_items[0].tmo;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.data_byte   = out_data_byte;
      got.data_valid  = out_data_valid;
      got.done_res    = out_done_res;
      got.status      = status_t'(out_status);
      got.frame_addr  = out_frame_addr;
      got.frame_cmd   = out_frame_cmd;
      got.data_len    = out_data_len;
      got.checksum_ok = out_checksum_ok;
      if (expected_results.size() == 0) begin
        if (fail_count < 10)
          $display("%0t: result with nothing expected: byte=%h done=%b st=%0d",
                   $realtime, got.data_byte, got.done_res, got.status);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.data_byte !== want.data_byte || got.data_valid !== want.data_valid ||
            got.done_res !== want.done_res || got.status !== want.status ||
            got.frame_addr !== want.frame_addr || got.frame_cmd !== want.frame_cmd ||
            got.data_len !== want.data_len || got.checksum_ok !== want.checksum_ok) begin
          if (fail_count < 10) begin
            $display("%0t: mismatch byte/dv/done/st/addr/cmd/len/chk", $realtime);
            $display("  got  %h %b %b %0d %h %h %0d %b", got.data_byte, got.data_valid,
                     got.done_res, got.status, got.frame_addr, got.frame_cmd,
                     got.data_len, got.checksum_ok);
            $display("  want %h %b %b %0d %h %h %0d %b", want.data_byte, want.data_valid,
                     want.done_res, want.status, want.frame_addr, want.frame_cmd,
                     want.data_len, want.checksum_ok);
          end
          fail_count++;
        end
        if (want.data_valid) payload_bytes++;
        else if (want.status == ST_OK) frames_ok++;
        else if (want.status == ST_REJECTED) frames_rejected++;
        else timeouts_seen++;
      end
    end
    out_stall <= ($urandom_range(99) < (no_gaps ? 0 : GAP_PCT));
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Run stopped at %0d cycles with %0d items pending, %0d results expected",
               cycle_cnt, line_items.size(), expected_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic push_item(input logic [7:0] b, input logic t);
    line_items.push_back('{rx: b, tmo: t});
    items_queued++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_EXP_ADDR:  exp_addr_cfg = val;
      REG_HOST_MODE: host_cfg = val[0];
      REG_EXP_CMD:   exp_cmd_cfg = val;
      default:       skip_cfg = val;
    endcase
  endtask

  // Wait until no item is pending, nothing is expected and the block has been quiet a while
  task automatic wait_line_quiet();
    int quiet;
    quiet = 0;
    while (quiet < QUIET_CYCLES) begin
      @(negedge clk);
      if (line_items.size() == 0 && !in_valid && expected_results.size() == 0 && !out_valid)
        quiet++;
      else
        quiet = 0;
    end
  endtask

  // Line noise that the address hunt passes over, with the odd timeout
  task automatic queue_noise();
    logic [7:0] b;
    if ($urandom_range(99) < 15) begin
      push_item(8'($urandom_range(255)), 1'b1);
    end else begin
      do b = 8'($urandom_range(255));
      while ((host_cfg ? (b & HOST_ADDR_MASK) : b) == exp_addr_cfg);
      push_item(b, 1'b0);
    end
  endtask

  // Queue one frame built for the current settings, sometimes cut short or corrupted
  task automatic queue_frame(input int force_len);
    logic [7:0] fb[$];
    logic [7:0] x;
    logic [7:0] chk;
    int         len;
    int         ndata;
    int         brk;
    int         cut;
    int         last;
    repeat ($urandom_range(0, 2)) queue_noise();
    if (force_len >= 0) len = force_len;
    else if ($urandom_range(99) < 85) len = $urandom_range(0, 12);
    else if ($urandom_range(99) < 65) len = $urandom_range(13, 40);
    else len = $urandom_range(0, 255);
    x = 8'($urandom_range(255));
    fb.push_back(host_cfg ? {x[7:4], exp_addr_cfg[3:0]} : exp_addr_cfg);
    fb.push_back(len[7:0]);
    if (host_cfg || $urandom_range(99) >= 85) fb.push_back(8'($urandom_range(255)));
    else fb.push_back(exp_cmd_cfg | ACK_BIT);
    ndata = len - 2 - int'(skip_cfg);
    if (ndata < 0) ndata = 0;
    repeat (int'(skip_cfg) + ndata) fb.push_back(8'($urandom_range(255)));
    chk = 8'h00;
    foreach (fb[i]) chk = chk ^ fb[i];
    fb.push_back(chk);
    last = fb.size() - 1;
    cut  = fb.size();
    brk  = $urandom_range(99);
    if (brk < 8) cut = $urandom_range(1, last);
    else if (brk < 16) fb[last] = fb[last] ^ 8'($urandom_range(1, 255));
    else if (brk < 21) cut = last;
    for (int i = 0; i < cut; i++) push_item(fb[i], 1'b0);
    if (cut < fb.size()) push_item(8'($urandom_range(255)), 1'b1);
  endtask

  initial begin
    int         ph;
    int         phase_end;
    logic [7:0] a;
    logic [7:0] c;
    logic [7:0] s;
    logic       h;
    warmup = '{
      TMO, 9'h0ff,                             // timeout while hunting, noise
      9'h000, 9'h003, 9'h080, 9'h0a5, 9'h026,  // good frame, one payload byte
      9'h000, 9'h002, 9'h07f,                  // command is not the acknowledgement
      9'h000, 9'h005, 9'h080, 9'h011, TMO,     // timeout inside the payload
      9'h000, 9'h002, 9'h080, TMO,             // timeout in place of the checksum
      9'h000, 9'h000, 9'h080, 9'h080,          // length below the header size
      9'h000, 9'h002, 9'h080, 9'h055           // wrong checksum
    };
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (warmup[i]) push_item(warmup[i][7:0], warmup[i][8]);

    ph = 0;
    while (items_queued < ITEM_TARGET + 27) begin
      wait_line_quiet();
      case (ph)
        0: begin a = 8'($urandom_range(255)); h = 1'b0; c = 8'($urandom_range(255)); s = 8'd0; end
        1: begin a = 8'($urandom_range(15)); h = 1'b1; c = 8'($urandom_range(255)); s = 8'd1; end
        2: begin a = 8'hff; h = 1'b0; c = 8'hff; s = 8'hff; end
        3: begin a = 8'hf0; h = 1'b1; c = 8'h00; s = 8'h00; end
        4: begin a = 8'h00; h = 1'b0; c = 8'h7f; s = 8'd2; end
        default: begin
          h = 1'($urandom_range(1));
          a = h ? 8'($urandom_range(15)) : 8'($urandom_range(255));
          c = 8'($urandom_range(255));
          s = ($urandom_range(99) < 80) ? 8'($urandom_range(4)) : 8'($urandom_range(5, 30));
        end
      endcase
      write_reg(REG_EXP_ADDR, a);
      write_reg(REG_HOST_MODE, {7'd0, h});
      write_reg(REG_EXP_CMD, c);
      write_reg(REG_SKIP_CNT, s);
      settings_used++;
      no_gaps = (ph == 4);
      @(negedge clk);
      phase_end = items_queued + ((ph == 3) ? 40 : 150);
      // Longest payload, and the largest skip with a full and a short length
      if (ph == 0) queue_frame(255);
      if (ph == 2) begin
        queue_frame(255);
        queue_frame(3);
        phase_end = items_queued;
      end
      while (items_queued < phase_end) queue_frame(-1);
      ph++;
    end

    wait_line_quiet();
    fail_count += expected_results.size();
    $display("Covered %0d line items over %0d register settings in %0d cycles",
             items_queued, settings_used, cycle_cnt);
    $display("Frames ok %0d, rejected %0d, timeouts %0d, payload bytes %0d",
             frames_ok, frames_rejected, timeouts_seen, payload_bytes);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d failures", fail_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
